// ----- src/fvdf_pkg.sv -----
// Package for the Farrow variable delay filter: sizes, transaction structs,
// control structs and state encodings shared by all modules of the block.
// No dependencies.
package fvdf_pkg;

    localparam int TAPS_DEF    = 48;
    localparam int ORDER_DEF   = 4;
    localparam int SAMPLE_BITS = 16;
    localparam int MU_BITS     = 16;
    localparam int COEF_BITS   = 16;
    localparam int COEF_FRAC   = 13;
    localparam int IDX_BITS    = 8;
    localparam int ACC_W       = 48;

    localparam logic ACT_COEF   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef struct packed {
        logic                          action;
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic        [MU_BITS-1:0]     mu_in;
        logic                          start_req;
        logic        [IDX_BITS-1:0]    coef_index;
        logic signed [COEF_BITS-1:0]   coef_value;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          clipped;
    } out_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

    typedef struct packed {
        logic start;
        logic first;
    } hrn_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_HORN,
        ST_HWAIT,
        ST_FINAL
    } state_t;

    typedef enum logic [2:0] {
        HP_IDLE,
        HP_LO,
        HP_HI,
        HP_SUM,
        HP_ACC
    } hrn_phase_t;

endpackage

// ----- src/farrow_variable_delay_filter.sv -----
// Top level of the Farrow variable delay filter: delay chains, sequencer,
// output rounding and output register. Depends on fvdf_pkg, fvdf_cell,
// fvdf_mac and fvdf_horner.
//
// A coefficient write and a sample that does not complete the window are each
// accepted only while the block is idle. A sample that yields an output keeps
// the block busy from its acceptance until every branch is folded in and the
// result is loaded. The sample ring rotates past a single multiply-accumulate
// unit that reads one coefficient word per cycle, once per branch. Each branch
// sum then passes the read, product and sum registers of that pipeline,
// and each branch after the first is folded in by a four-step Horner multiply.
// The result waits in an output register, so the next transaction is taken
// while it has not yet been collected; the block stalls only when a new result
// is ready and the previous one is still waiting.
module farrow_variable_delay_filter #(
    parameter int TAPS  = fvdf_pkg::TAPS_DEF,
    parameter int ORDER = fvdf_pkg::ORDER_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  fvdf_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output fvdf_pkg::out_t  out_data
);

    localparam int SB          = fvdf_pkg::SAMPLE_BITS;
    localparam int MU_W        = fvdf_pkg::MU_BITS;
    localparam int HALF        = TAPS / 2;
    localparam int STORE_DEPTH = (ORDER + 1) * TAPS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int KW          = $clog2(TAPS);
    localparam int FW          = $clog2(TAPS + 1);
    localparam int IW          = (ADDR_W + 1 > fvdf_pkg::IDX_BITS) ? ADDR_W + 1
                                                                   : fvdf_pkg::IDX_BITS;
    localparam int SUM_W       = SB + fvdf_pkg::COEF_BITS + $clog2(TAPS);
    localparam int ACC_W       = fvdf_pkg::ACC_W;
    localparam int RW          = ACC_W + 1;

    localparam logic [ADDR_W-1:0] BASE_TOP = ADDR_W'(ORDER * TAPS);
    localparam logic signed [RW-1:0] OUT_RND = RW'(1) << (fvdf_pkg::COEF_FRAC - 1);
    localparam logic signed [RW-1:0] OUT_HI = RW'(signed'({1'b0, {(SB - 1){1'b1}}}));
    localparam logic signed [RW-1:0] OUT_LO = RW'(signed'({1'b1, {(SB - 1){1'b0}}}));

    fvdf_pkg::state_t          state_reg;
    fvdf_pkg::state_t          state_next;
    logic [KW-1:0]             k_reg;
    logic [KW-1:0]             k_next;
    logic [ADDR_W-1:0]         base_reg;
    logic [ADDR_W-1:0]         base_next;
    logic [FW-1:0]             fill_reg;
    logic [FW-1:0]             fill_next;
    logic [FW-1:0]             fill_base;
    logic [FW-1:0]             fill_inc;
    logic [MU_W-1:0]           mu_cur_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    fvdf_pkg::out_t            out_data_reg;
    fvdf_pkg::out_t            out_data_next;

    logic                      smp_acc;
    logic                      emit;
    logic                      k_last;
    logic                      base_last;
    logic                      rotate;
    logic                      out_free;
    logic                      out_load;
    logic                      win_en;
    logic [SB-1:0]             win_q [TAPS];
    logic [MU_W-1:0]           mu_q [HALF];

    logic [IW-1:0]             idx_w;
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic [ADDR_W-1:0]         rd_addr;
    fvdf_pkg::mac_ctl_t        mac_ctl;
    logic signed [SUM_W-1:0]   mac_sum;
    logic                      mac_done;
    fvdf_pkg::hrn_ctl_t        hrn_ctl;
    logic                      hrn_busy;
    logic signed [ACC_W-1:0]   hrn_acc;
    logic signed [RW-1:0]      r_sum;
    logic signed [RW-1:0]      r_shift;

    assign smp_acc   = in_valid && in_ready && (in_data.action == fvdf_pkg::ACT_SAMPLE);
    assign k_last    = (k_reg == KW'(TAPS - 1));
    assign base_last = (base_reg == '0);
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        fill_base = in_data.start_req ? '0 : fill_reg;
        fill_inc  = (fill_base < FW'(TAPS)) ? fill_base + FW'(1) : fill_base;
        emit      = (fill_inc == FW'(TAPS));
    end

    always_comb
    begin
        idx_w   = IW'(in_data.coef_index);
        wr_en   = in_valid && in_ready && (in_data.action == fvdf_pkg::ACT_COEF)
                  && (idx_w < IW'(STORE_DEPTH));
        wr_addr = ADDR_W'(idx_w);
        rd_addr = base_reg + ADDR_W'(k_reg);
    end

    // Sample ring: shifts in new samples and rotates past the multiplier.
    assign win_en = smp_acc || rotate;

    for (genvar i = 0; i < TAPS; i++)
    begin : g_win
        logic [SB-1:0] d;
        if (i == 0)
        begin : g_head
            assign d = rotate ? win_q[TAPS-1] : in_data.sample_in;
        end
        else
        begin : g_body
            assign d = win_q[i-1];
        end
        fvdf_cell #(
            .W (SB)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (win_en),
            .d     (d),
            .q     (win_q[i])
        );
    end

    for (genvar i = 0; i < HALF; i++)
    begin : g_mu
        logic [MU_W-1:0] d;
        if (i == 0)
        begin : g_head
            assign d = in_data.mu_in;
        end
        else
        begin : g_body
            assign d = mu_q[i-1];
        end
        fvdf_cell #(
            .W (MU_W)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (smp_acc),
            .d     (d),
            .q     (mu_q[i])
        );
    end

    fvdf_mac #(
        .TAPS  (TAPS),
        .ORDER (ORDER)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mac_ctl),
        .rd_addr (rd_addr),
        .head    (win_q[TAPS-1]),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_data.coef_value),
        .sum     (mac_sum),
        .done    (mac_done)
    );

    fvdf_horner #(
        .TAPS (TAPS)
    ) u_horner (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (hrn_ctl),
        .mu     (mu_cur_reg),
        .branch (mac_sum),
        .busy   (hrn_busy),
        .acc    (hrn_acc)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fvdf_pkg::ST_IDLE:
            begin
                if (smp_acc && emit)
                begin
                    state_next = fvdf_pkg::ST_MAC;
                end
            end
            fvdf_pkg::ST_MAC:
            begin
                if (k_last)
                begin
                    state_next = fvdf_pkg::ST_DRAIN;
                end
            end
            fvdf_pkg::ST_DRAIN:
            begin
                if (mac_done)
                begin
                    state_next = fvdf_pkg::ST_HORN;
                end
            end
            fvdf_pkg::ST_HORN:
            begin
                state_next = fvdf_pkg::ST_HWAIT;
            end
            fvdf_pkg::ST_HWAIT:
            begin
                if (!hrn_busy)
                begin
                    state_next = base_last ? fvdf_pkg::ST_FINAL : fvdf_pkg::ST_MAC;
                end
            end
            fvdf_pkg::ST_FINAL:
            begin
                if (out_free)
                begin
                    state_next = fvdf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fvdf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = (state_reg == fvdf_pkg::ST_IDLE);
        rotate        = (state_reg == fvdf_pkg::ST_MAC);
        mac_ctl.valid = (state_reg == fvdf_pkg::ST_MAC);
        mac_ctl.first = (k_reg == '0);
        mac_ctl.last  = k_last;
        hrn_ctl.start = (state_reg == fvdf_pkg::ST_HORN);
        hrn_ctl.first = (base_reg == BASE_TOP);
        out_load      = (state_reg == fvdf_pkg::ST_FINAL) && out_free;
    end

    always_comb
    begin
        k_next    = k_reg;
        base_next = base_reg;
        fill_next = fill_reg;
        if (rotate)
        begin
            k_next = k_last ? '0 : k_reg + KW'(1);
        end
        if (smp_acc)
        begin
            fill_next = fill_inc;
            base_next = BASE_TOP;
        end
        if ((state_reg == fvdf_pkg::ST_HWAIT) && !hrn_busy && !base_last)
        begin
            base_next = base_reg - ADDR_W'(TAPS);
        end
    end

    always_comb
    begin
        r_sum   = RW'(hrn_acc) + OUT_RND;
        r_shift = r_sum >>> fvdf_pkg::COEF_FRAC;
        if (r_shift > OUT_HI)
        begin
            out_data_next.sample_out = SB'(OUT_HI);
            out_data_next.clipped    = 1'b1;
        end
        else if (r_shift < OUT_LO)
        begin
            out_data_next.sample_out = SB'(OUT_LO);
            out_data_next.clipped    = 1'b1;
        end
        else
        begin
            out_data_next.sample_out = SB'(r_shift);
            out_data_next.clipped    = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (smp_acc)
        begin
            mu_cur_reg <= mu_q[HALF-1];
        end
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fvdf_pkg::ST_IDLE;
            k_reg         <= '0;
            base_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            base_reg      <= base_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> (state_reg == fvdf_pkg::ST_DRAIN))
        else $error("Branch sum completed outside the drain state.");

    a_horner_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fvdf_pkg::ST_MAC) |-> !hrn_busy)
        else $error("Horner unit busy while a branch sum is being formed.");

    a_ring_restored: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fvdf_pkg::ST_DRAIN) |-> (k_reg == '0))
        else $error("Sample ring not returned to its home position.");

    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fvdf_pkg::ST_FINAL) |-> base_last)
        else $error("Output formed before the last branch.");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(TAPS))
        else $error("Window fill count beyond the tap count.");
`endif

endmodule

// ----- src/fvdf_cell.sv -----
// One cell of the delay chain: a word that takes its neighbor's value when enabled.
// Depends on fvdf_pkg.
module fvdf_cell #(
    parameter int W = fvdf_pkg::SAMPLE_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] word_reg;
    logic [W-1:0] word_next;

    always_comb
    begin
        word_next = en ? d : word_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

    assign q = word_reg;

endmodule

// ----- src/fvdf_mac.sv -----
// Coefficient memory and the shared multiply-accumulate unit that forms one branch sum.
// Depends on fvdf_pkg.
module fvdf_mac #(
    parameter int TAPS  = fvdf_pkg::TAPS_DEF,
    parameter int ORDER = fvdf_pkg::ORDER_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  fvdf_pkg::mac_ctl_t                           ctl,
    input  logic [$clog2((ORDER + 1) * TAPS)-1:0]        rd_addr,
    input  logic [fvdf_pkg::SAMPLE_BITS-1:0]             head,
    input  logic                                         wr_en,
    input  logic [$clog2((ORDER + 1) * TAPS)-1:0]        wr_addr,
    input  logic signed [fvdf_pkg::COEF_BITS-1:0]        wr_data,
    output logic signed [fvdf_pkg::SAMPLE_BITS + fvdf_pkg::COEF_BITS
                        + $clog2(TAPS)-1:0]              sum,
    output logic                                         done
);

    localparam int STORE_DEPTH = (ORDER + 1) * TAPS;
    localparam int PROD_W      = fvdf_pkg::SAMPLE_BITS + fvdf_pkg::COEF_BITS;
    localparam int SUM_W       = PROD_W + $clog2(TAPS);

    logic signed [fvdf_pkg::COEF_BITS-1:0] mem [STORE_DEPTH];

    logic signed [fvdf_pkg::COEF_BITS-1:0] coef_rd_reg;
    logic [fvdf_pkg::SAMPLE_BITS-1:0]      smp1_reg;
    fvdf_pkg::mac_ctl_t                    s1_ctl_reg;
    logic signed [PROD_W-1:0]              prod_reg;
    logic signed [PROD_W-1:0]              prod_next;
    fvdf_pkg::mac_ctl_t                    s2_ctl_reg;
    logic signed [SUM_W-1:0]               sum_reg;
    logic signed [SUM_W-1:0]               sum_next;
    logic                                  done_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.valid)
        begin
            coef_rd_reg <= mem[rd_addr];
            smp1_reg    <= head;
        end
    end

    always_comb
    begin
        prod_next = coef_rd_reg * signed'(smp1_reg);
        sum_next  = s2_ctl_reg.first ? SUM_W'(prod_reg) : sum_reg + SUM_W'(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        if (s1_ctl_reg.valid)
        begin
            prod_reg <= prod_next;
        end
        if (s2_ctl_reg.valid)
        begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_ctl_reg <= ctl;
            s2_ctl_reg <= s1_ctl_reg;
            done_reg   <= s2_ctl_reg.valid & s2_ctl_reg.last;
        end
    end

    assign sum  = sum_reg;
    assign done = done_reg;

endmodule

// ----- src/fvdf_horner.sv -----
// Horner evaluation unit: folds branch sums into the accumulator with a
// split multiply by mu, rounding and saturation. Depends on fvdf_pkg.
module fvdf_horner #(
    parameter int TAPS = fvdf_pkg::TAPS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  fvdf_pkg::hrn_ctl_t                     ctl,
    input  logic [fvdf_pkg::MU_BITS-1:0]           mu,
    input  logic signed [fvdf_pkg::SAMPLE_BITS + fvdf_pkg::COEF_BITS
                        + $clog2(TAPS)-1:0]        branch,
    output logic                                   busy,
    output logic signed [fvdf_pkg::ACC_W-1:0]      acc
);

    localparam int ACC_W  = fvdf_pkg::ACC_W;
    localparam int HALF_W = ACC_W / 2;
    localparam int MU_W   = fvdf_pkg::MU_BITS;
    localparam int LO_W   = HALF_W + MU_W;
    localparam int HI_W   = (ACC_W - HALF_W) + MU_W + 1;
    localparam int PF_W   = ACC_W + MU_W + 1;
    localparam int SW     = ACC_W + 2;

    localparam logic signed [PF_W-1:0] MU_RND = PF_W'(1) << (MU_W - 1);
    localparam logic signed [SW-1:0] SAT_HI = SW'(signed'({1'b0, {(ACC_W - 1){1'b1}}}));
    localparam logic signed [SW-1:0] SAT_LO = SW'(signed'({1'b1, {(ACC_W - 1){1'b0}}}));

    fvdf_pkg::hrn_phase_t      phase_reg;
    fvdf_pkg::hrn_phase_t      phase_next;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic [LO_W-1:0]           plo_reg;
    logic [LO_W-1:0]           plo_next;
    logic signed [HI_W-1:0]    phi_reg;
    logic signed [HI_W-1:0]    phi_next;
    logic signed [PF_W-1:0]    full_reg;
    logic signed [PF_W-1:0]    full_next;
    logic signed [PF_W-1:0]    full_shift;
    logic signed [SW-1:0]      step_sum;

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            fvdf_pkg::HP_IDLE:
            begin
                if (ctl.start && !ctl.first)
                begin
                    phase_next = fvdf_pkg::HP_LO;
                end
            end
            fvdf_pkg::HP_LO:  phase_next = fvdf_pkg::HP_HI;
            fvdf_pkg::HP_HI:  phase_next = fvdf_pkg::HP_SUM;
            fvdf_pkg::HP_SUM: phase_next = fvdf_pkg::HP_ACC;
            fvdf_pkg::HP_ACC: phase_next = fvdf_pkg::HP_IDLE;
            default:          phase_next = fvdf_pkg::HP_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (phase_reg != fvdf_pkg::HP_IDLE);
    end

    always_comb
    begin
        plo_next   = LO_W'(acc_reg[HALF_W-1:0]) * LO_W'(mu);
        phi_next   = HI_W'(signed'(acc_reg[ACC_W-1:HALF_W])) * HI_W'(signed'({1'b0, mu}));
        full_next  = (PF_W'(phi_reg) <<< HALF_W) + signed'(PF_W'(plo_reg)) + MU_RND;
        full_shift = full_reg >>> MU_W;
        step_sum   = SW'(full_shift) + SW'(branch);
        if (step_sum > SAT_HI)
        begin
            acc_next = ACC_W'(SAT_HI);
        end
        else if (step_sum < SAT_LO)
        begin
            acc_next = ACC_W'(SAT_LO);
        end
        else
        begin
            acc_next = ACC_W'(step_sum);
        end
    end

    always_ff @(posedge clk)
    begin
        case (phase_reg)
            fvdf_pkg::HP_IDLE:
            begin
                if (ctl.start && ctl.first)
                begin
                    acc_reg <= ACC_W'(branch);
                end
            end
            fvdf_pkg::HP_LO:  plo_reg  <= plo_next;
            fvdf_pkg::HP_HI:  phi_reg  <= phi_next;
            fvdf_pkg::HP_SUM: full_reg <= full_next;
            fvdf_pkg::HP_ACC: acc_reg  <= acc_next;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= fvdf_pkg::HP_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ----- bench/fvdf_checker.sv -----
// Checker for the Farrow variable delay filter: watches both channels, predicts
// every output from the accepted input transactions and compares field by field.
// Depends on fvdf_pkg.
`timescale 1ns / 1ps

module fvdf_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_ready,
    input  fvdf_pkg::in_t  in_data,
    input  logic           out_valid,
    input  logic           out_ready,
    input  fvdf_pkg::out_t out_data,
    output int             errors,
    output int             pending
);

    localparam int     TAPS        = fvdf_pkg::TAPS_DEF;
    localparam int     HALF        = TAPS / 2;
    localparam int     BRANCHES    = fvdf_pkg::ORDER_DEF + 1;
    localparam int     STORE_DEPTH = BRANCHES * TAPS;
    localparam int     SB          = fvdf_pkg::SAMPLE_BITS;
    localparam int     MU_W        = fvdf_pkg::MU_BITS;
    localparam int     CW          = fvdf_pkg::COEF_BITS;
    localparam int     FRAC        = fvdf_pkg::COEF_FRAC;
    localparam longint ACC_MAX     = (64'sd1 <<< (fvdf_pkg::ACC_W - 1)) - 64'sd1;
    localparam longint ACC_MIN     = -(64'sd1 <<< (fvdf_pkg::ACC_W - 1));
    localparam longint OUT_MAX     = (64'sd1 <<< (SB - 1)) - 64'sd1;
    localparam longint OUT_MIN     = -(64'sd1 <<< (SB - 1));

    logic signed [SB-1:0]          history [TAPS];
    logic        [MU_W-1:0]        mu_history [HALF];
    logic signed [CW-1:0]          coef_words [STORE_DEPTH];
    int                            stream_len;
    int                            mismatches;
    fvdf_pkg::out_t                expected_outputs [$];

    function automatic fvdf_pkg::out_t farrow_output(input logic [MU_W-1:0] mu);
        longint         branch_sum [BRANCHES];
        longint         acc;
        longint         rounded;
        fvdf_pkg::out_t res;
        for (int b = 0; b < BRANCHES; b++)
        begin
            branch_sum[b] = 0;
            for (int k = 0; k < TAPS; k++)
            begin
                branch_sum[b] += longint'(coef_words[b * TAPS + k])
                               * longint'(history[TAPS - 1 - k]);
            end
        end
        acc = branch_sum[BRANCHES - 1];
        for (int b = BRANCHES - 2; b >= 0; b--)
        begin
            acc = ((acc * longint'(mu)) + (64'sd1 <<< (MU_W - 1))) >>> MU_W;
            acc += branch_sum[b];
            if (acc > ACC_MAX)
                acc = ACC_MAX;
            else if (acc < ACC_MIN)
                acc = ACC_MIN;
        end
        rounded = (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
        res.clipped = 1'b1;
        if (rounded > OUT_MAX)
            rounded = OUT_MAX;
        else if (rounded < OUT_MIN)
            rounded = OUT_MIN;
        else
            res.clipped = 1'b0;
        res.sample_out = rounded[SB-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0d ns checker: %s", $time, what);
        mismatches++;
    endtask

    task automatic take_transaction(input fvdf_pkg::in_t t);
        logic [MU_W-1:0] centre_mu;
        if (t.action == fvdf_pkg::ACT_COEF)
        begin
            if (t.coef_index < STORE_DEPTH)
                coef_words[t.coef_index] = t.coef_value;
        end
        else
        begin
            if (t.start_req)
                stream_len = 0;
            centre_mu = mu_history[HALF - 1];
            for (int i = HALF - 1; i > 0; i--)
                mu_history[i] = mu_history[i - 1];
            mu_history[0] = t.mu_in;
            for (int i = TAPS - 1; i > 0; i--)
                history[i] = history[i - 1];
            history[0] = t.sample_in;
            if (stream_len < TAPS)
                stream_len++;
            if (stream_len == TAPS)
                expected_outputs.push_back(farrow_output(centre_mu));
        end
    endtask

    task automatic check_output(input fvdf_pkg::out_t got);
        fvdf_pkg::out_t want;
        if (expected_outputs.size() == 0)
        begin
            report_mismatch($sformatf("output %0d with nothing expected", got.sample_out));
        end
        else
        begin
            want = expected_outputs.pop_front();
            if (got.sample_out !== want.sample_out)
                report_mismatch($sformatf("sample_out got %0d expected %0d",
                                          got.sample_out, want.sample_out));
            if (got.clipped !== want.clipped)
                report_mismatch($sformatf("clipped got %0b expected %0b",
                                          got.clipped, want.clipped));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
                history[i] = '0;
            for (int i = 0; i < HALF; i++)
                mu_history[i] = '0;
            stream_len = 0;
            mismatches = 0;
            expected_outputs.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_output(out_data);
            if (in_valid && in_ready)
                take_transaction(in_data);
            errors  <= mismatches;
            pending <= expected_outputs.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
// Testbench top for the Farrow variable delay filter: clock, reset, stimulus
// and verdict. Depends on fvdf_pkg, farrow_variable_delay_filter and fvdf_checker.
`timescale 1ns / 1ps

module tb;

    localparam int TAPS         = fvdf_pkg::TAPS_DEF;
    localparam int STORE_DEPTH  = (fvdf_pkg::ORDER_DEF + 1) * TAPS;
    localparam int SB           = fvdf_pkg::SAMPLE_BITS;
    localparam int MU_W         = fvdf_pkg::MU_BITS;
    localparam int IDX_W        = fvdf_pkg::IDX_BITS;
    localparam int CW           = fvdf_pkg::COEF_BITS;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 300;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    fvdf_pkg::in_t  in_data;
    logic           out_valid;
    logic           out_ready;
    fvdf_pkg::out_t out_data;
    int             send_idle_pct;
    int             recv_idle_pct;
    int             errors;
    int             pending;

    farrow_variable_delay_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    fvdf_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("tb: errors");
        $finish;
    end

    function automatic fvdf_pkg::in_t coef_item(input int index, input int value);
        fvdf_pkg::in_t t;
        t.action     = fvdf_pkg::ACT_COEF;
        t.sample_in  = SB'($urandom);
        t.mu_in      = MU_W'($urandom);
        t.start_req  = 1'($urandom);
        t.coef_index = IDX_W'(index);
        t.coef_value = CW'(value);
        return t;
    endfunction

    function automatic fvdf_pkg::in_t sample_item(input int value, input int mu,
                                                  input bit restart);
        fvdf_pkg::in_t t;
        t.action     = fvdf_pkg::ACT_SAMPLE;
        t.sample_in  = SB'(value);
        t.mu_in      = MU_W'(mu);
        t.start_req  = restart;
        t.coef_index = IDX_W'($urandom);
        t.coef_value = CW'($urandom);
        return t;
    endfunction

    function automatic int small_coef();
        return int'($urandom_range(600)) - 300;
    endfunction

    function automatic int random_coef();
        if ($urandom_range(19) == 0)
            return int'($urandom_range(65535)) - 32768;
        return small_coef();
    endfunction

    function automatic int random_sample();
        case ($urandom_range(9))
            0: return ($urandom_range(1) != 0) ? 32767 : -32768;
            1: return int'($urandom_range(16)) - 8;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    function automatic int random_mu();
        case ($urandom_range(9))
            0: return 0;
            1: return 65535;
            default: return int'($urandom_range(65535));
        endcase
    endfunction

    task automatic send_item(input fvdf_pkg::in_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic run_random(input int count);
        int pick;
        int index;
        for (int i = 0; i < count; i++)
        begin
            pick = int'($urandom_range(199));
            if (pick < 14)
            begin
                index = ($urandom_range(4) == 0) ? int'($urandom_range(255))
                                                 : int'($urandom_range(STORE_DEPTH - 1));
                send_item(coef_item(index, random_coef()));
            end
            else
            begin
                send_item(sample_item(random_sample(), random_mu(), pick == 199));
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_ready     = 1'b0;
        send_idle_pct = 27;
        recv_idle_pct = 78;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Every coefficient word is written before the window first fills.
        for (int k = 0; k < STORE_DEPTH; k++)
            send_item(coef_item(k, small_coef()));
        for (int k = 0; k < TAPS / 2; k++)
            send_item(sample_item(-32768, k[0] ? 65535 : 0, k == 0));
        for (int k = 0; k < TAPS / 2 - 1; k++)
            send_item(sample_item(32767, k[0] ? 0 : 65535, 1'b0));

        // The oldest samples are negative full scale, so a full-scale tap on
        // the oldest position drives the output into either rail.
        send_item(coef_item(0, 32767));
        send_item(sample_item(32767, 0, 1'b0));
        send_item(coef_item(0, -32768));
        send_item(sample_item(0, 65535, 1'b0));
        send_item(coef_item(0, small_coef()));
        send_item(coef_item(STORE_DEPTH, -32768));
        send_item(coef_item(255, 32767));
        send_item(sample_item(-1, 65535, 1'b0));
        send_item(sample_item(1, 0, 1'b0));
        send_item(sample_item(0, 32768, 1'b0));
        send_item(sample_item(-32768, 1, 1'b0));
        send_item(coef_item(STORE_DEPTH - 1, 32767));
        send_item(sample_item(32767, 65535, 1'b0));
        send_item(coef_item(STORE_DEPTH - 1, small_coef()));
        send_item(sample_item(-32768, 65535, 1'b1));

        run_random(300);
        send_idle_pct = 78;
        recv_idle_pct = 27;
        run_random(300);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(248);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
